// File: rtl/core/cs_pkg.sv
// Shared types and character codes for the comment stripper.
`timescale 1ns / 1ps

package cs_pkg;

  localparam int unsigned BURST_MAX = 4;
  localparam int unsigned BIDX_W    = $clog2(BURST_MAX);
  localparam int unsigned BCNT_W    = $clog2(BURST_MAX + 1);
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QPTR_W    = $clog2(QDEPTH);
  localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_STRING = 2'd1,
    MODE_LINE   = 2'd2,
    MODE_BLOCK  = 2'd3
  } mode_t;

  // All results caused by one input beat.
  typedef struct packed {
    logic [BCNT_W-1:0]          cnt;
    logic [BURST_MAX-1:0][7:0]  ch;
    logic [BURST_MAX-1:0]       mark;
  } burst_t;

  // Queue occupancy seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: rtl/core/cs_front.sv
// Front end: accepts source beats, tracks scan state, builds result bursts.
`timescale 1ns / 1ps

module cs_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  logic [7:0]     char_in,
  input  logic           end_of_line,
  input  cs_pkg::q_status_t q_status,
  output logic           push,
  output cs_pkg::burst_t push_burst
);
  import cs_pkg::*;

  mode_t mode, mode_next;
  logic  slash_held, slash_held_next;
  logic  star_seen, star_seen_next;
  logic  backslash_before, backslash_before_next;
  logic  plain;
  logic  [BCNT_W-1:0] n;
  logic  take;

  assign item_stall = q_status.full;
  assign take       = item_valid && !q_status.full;
  assign push       = take && (push_burst.cnt != '0);

  always_comb begin
    mode_next             = mode;
    slash_held_next       = slash_held;
    star_seen_next        = star_seen;
    backslash_before_next = backslash_before;
    push_burst            = '0;
    n                     = '0;
    plain                 = 1'b0;
    if (end_of_line) begin
      // flush a held slash ahead of the line mark
      if (slash_held) begin
        push_burst.ch[0] = CH_SLASH;
        n = BCNT_W'(1);
      end
      push_burst.mark[n[BIDX_W-1:0]] = 1'b1;
      n = n + BCNT_W'(1);
      slash_held_next = 1'b0;
      if (mode != MODE_BLOCK) mode_next = MODE_NORMAL;
      star_seen_next        = 1'b0;
      backslash_before_next = 1'b0;
    end else begin
      case (mode)
        MODE_NORMAL: begin
          plain = 1'b1;
          if (slash_held) begin
            slash_held_next = 1'b0;
            if (char_in == CH_SLASH) begin
              push_burst.ch[0] = CH_SLASH;
              push_burst.ch[1] = CH_SLASH;
              n = BCNT_W'(2);
              mode_next = MODE_LINE;
              plain = 1'b0;
            end else if (char_in == CH_STAR) begin
              push_burst.ch[0] = CH_SLASH;
              push_burst.ch[1] = CH_STAR;
              push_burst.ch[2] = CH_STAR;
              push_burst.ch[3] = CH_SLASH;
              n = BCNT_W'(4);
              mode_next      = MODE_BLOCK;
              star_seen_next = 1'b0;
              plain = 1'b0;
            end else begin
              push_burst.ch[0] = CH_SLASH;
              n = BCNT_W'(1);
            end
          end
          if (plain) begin
            if (char_in == CH_SLASH) begin
              slash_held_next       = 1'b1;
              backslash_before_next = 1'b0;
            end else begin
              push_burst.ch[n[BIDX_W-1:0]] = char_in;
              n = n + BCNT_W'(1);
              if (char_in == CH_QUOTE && !backslash_before) mode_next = MODE_STRING;
              backslash_before_next = (char_in == CH_BACKSLASH);
            end
          end
        end
        MODE_STRING: begin
          push_burst.ch[0] = char_in;
          n = BCNT_W'(1);
          if (char_in == CH_QUOTE) mode_next = MODE_NORMAL;
          backslash_before_next = 1'b0;
        end
        MODE_LINE: begin
          // drop the rest of the line
        end
        default: begin
          if (star_seen && char_in == CH_SLASH) begin
            mode_next             = MODE_NORMAL;
            star_seen_next        = 1'b0;
            backslash_before_next = 1'b0;
          end else begin
            star_seen_next = (char_in == CH_STAR);
          end
        end
      endcase
    end
    push_burst.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= MODE_NORMAL;
      slash_held       <= 1'b0;
      star_seen        <= 1'b0;
      backslash_before <= 1'b0;
    end else if (take) begin
      mode             <= mode_next;
      slash_held       <= slash_held_next;
      star_seen        <= star_seen_next;
      backslash_before <= backslash_before_next;
    end
  end

endmodule

// File: rtl/core/cs_queue.sv
// Short burst queue between the front and the back.
`timescale 1ns / 1ps

module cs_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cs_pkg::burst_t    push_burst,
  input  logic              pop,
  output cs_pkg::burst_t    head,
  output cs_pkg::q_status_t q_status
);
  import cs_pkg::*;

  burst_t             entries [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign head           = entries[rd_ptr];
  assign q_status.full  = (count == QCNT_W'(QDEPTH));
  assign q_status.empty = (count == '0);

  function automatic logic [QPTR_W-1:0] advance(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_burst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= advance(wr_ptr);
      if (pop)  rd_ptr <= advance(rd_ptr);
      if (push && !pop)      count <= count + QCNT_W'(1);
      else if (pop && !push) count <= count - QCNT_W'(1);
    end
  end

endmodule

// File: rtl/core/cs_back.sv
// Back end: sends the head burst one result beat at a time.
`timescale 1ns / 1ps

module cs_back (
  input  logic              clk,
  input  logic              rst,
  input  cs_pkg::burst_t    head,
  input  cs_pkg::q_status_t q_status,
  output logic              pop,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [7:0]        char_out,
  output logic              line_mark,
  output logic              last
);
  import cs_pkg::*;

  logic [BIDX_W-1:0] idx;
  logic              send;

  assign result_valid = !q_status.empty;
  assign char_out     = head.ch[idx];
  assign line_mark    = head.mark[idx];
  assign last         = ({1'b0, idx} + BCNT_W'(1)) == head.cnt;
  assign send         = result_valid && !result_stall;
  assign pop          = send && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (send) begin
      // advance within the burst, rewind once its final beat goes
      idx <= last ? '0 : idx + BIDX_W'(1);
    end
  end

endmodule

// File: rtl/core/comment_stripper.sv
// Top level of the streaming C/C++ comment stripper.
`timescale 1ns / 1ps

// Takes one source byte or line-end beat per cycle and emits the cleaned text,
// each beat causing zero to four result beats, the final one flagged by last.
// The front updates the scan state and hands each non-empty result burst to a
// four-entry queue; the back sends the queue head one result beat a cycle while
// result_stall is low, straight from the queue registers, starting the cycle
// after the item is taken if the queue was empty. The input can take a new item
// while earlier bursts are still being sent. Multi-beat bursts (a comment opener
// gives four beats, a flushed slash with line mark two) pile up in the queue;
// once four bursts wait the input stalls until the back pops one. Items that
// cause no result (held slash, comment text) never enter the queue.
module comment_stripper (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [7:0] char_in,
  input  logic       end_of_line,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] char_out,
  output logic       line_mark,
  output logic       last
);
  import cs_pkg::*;

  q_status_t q_status;
  burst_t    push_burst;
  burst_t    head;
  logic      push;
  logic      pop;

  cs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .char_in    (char_in),
    .end_of_line(end_of_line),
    .q_status   (q_status),
    .push       (push),
    .push_burst (push_burst)
  );

  cs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_burst(push_burst),
    .pop       (pop),
    .head      (head),
    .q_status  (q_status)
  );

  cs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_status    (q_status),
    .pop         (pop),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .char_out    (char_out),
    .line_mark   (line_mark),
    .last        (last)
  );

`ifndef SYNTHESIS
  // a burst that has started is finished before anything else
  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && !last |=> result_valid)
    else $error("result burst broken off");

  // a line mark always closes its burst and carries no character
  a_mark_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && line_mark |-> last && char_out == 8'h00)
    else $error("line mark not final or carries a character");

  // the queue never holds an empty burst
  a_head_nonempty: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> head.cnt != '0)
    else $error("empty burst at queue head");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_valid && !item_stall)
    else $error("outputs active after reset");
`endif

endmodule

// File: bench/comment_stripper_tb.sv
// Self-checking testbench for the streaming C/C++ comment stripper.
`timescale 1ns / 1ps

module comment_stripper_tb;
  import cs_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TEXT_ITEMS  = 200;
  localparam int HOLD_AT     = 120;
  localparam int HOLD_CYCLES = 100;
  localparam int MAX_REPORTS = 200;

  typedef struct packed {
    logic [7:0] ch;
    logic       eol;
  } src_beat_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       mark;
    logic       fin;
  } clean_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_stall;
  logic [7:0] char_in = 8'h00;
  logic       end_of_line = 1'b0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic [7:0] char_out;
  logic       line_mark;
  logic       last;

  src_beat_t   src_pending[$];
  clean_beat_t text_due[$];
  src_beat_t   nxt;
  clean_beat_t got, want;

  // scanner copy kept alongside the block
  mode_t scan        = MODE_NORMAL;
  bit    slash_wait  = 1'b0;
  bit    star_prev   = 1'b0;
  bit    bslash_prev = 1'b0;

  int  errors = 0;
  int  cycles = 0;
  int  beats_in = 0;
  int  send_gap = 0;
  int  stall_left = 0;
  bit  hold_done = 1'b0;

  comment_stripper dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .char_in      (char_in),
    .end_of_line  (end_of_line),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .char_out     (char_out),
    .line_mark    (line_mark),
    .last         (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic void queue_beat(logic [7:0] c, logic eol);
    src_beat_t b;
    b.ch  = c;
    b.eol = eol;
    src_pending.push_back(b);
  endfunction

  // idle only well before the end, and in alternating stretches
  function automatic bit idle_ok();
    return src_pending.size() >= 40 && (src_pending.size() / 25) % 3 != 0;
  endfunction

  function automatic void add_clean(logic [7:0] c, logic m);
    clean_beat_t r;
    r.ch   = c;
    r.mark = m;
    r.fin  = 1'b0;
    text_due.push_back(r);
  endfunction

  function automatic void keep_plain(logic [7:0] c);
    if (c == CH_SLASH) begin
      slash_wait  = 1'b1;
      bslash_prev = 1'b0;
    end else begin
      add_clean(c, 1'b0);
      if (c == CH_QUOTE && !bslash_prev) scan = MODE_STRING;
      bslash_prev = (c == CH_BACKSLASH);
    end
  endfunction

  // Work out the cleaned beats one source beat causes and queue them.
  function automatic void strip_beat(logic [7:0] c, logic eol);
    int          n0;
    clean_beat_t tail;
    n0 = text_due.size();
    if (eol) begin
      if (slash_wait) add_clean(CH_SLASH, 1'b0);
      slash_wait = 1'b0;
      add_clean(8'h00, 1'b1);
      if (scan != MODE_BLOCK) scan = MODE_NORMAL;
      star_prev   = 1'b0;
      bslash_prev = 1'b0;
    end else begin
      case (scan)
        MODE_NORMAL: begin
          if (slash_wait) begin
            slash_wait = 1'b0;
            if (c == CH_SLASH) begin
              add_clean(CH_SLASH, 1'b0);
              add_clean(CH_SLASH, 1'b0);
              scan = MODE_LINE;
            end else if (c == CH_STAR) begin
              add_clean(CH_SLASH, 1'b0);
              add_clean(CH_STAR, 1'b0);
              add_clean(CH_STAR, 1'b0);
              add_clean(CH_SLASH, 1'b0);
              scan      = MODE_BLOCK;
              star_prev = 1'b0;
            end else begin
              add_clean(CH_SLASH, 1'b0);
              keep_plain(c);
            end
          end else begin
            keep_plain(c);
          end
        end
        MODE_STRING: begin
          add_clean(c, 1'b0);
          if (c == CH_QUOTE) scan = MODE_NORMAL;
          bslash_prev = 1'b0;
        end
        MODE_LINE: begin
        end
        default: begin
          if (star_prev && c == CH_SLASH) begin
            scan        = MODE_NORMAL;
            star_prev   = 1'b0;
            bslash_prev = 1'b0;
          end else begin
            star_prev = (c == CH_STAR);
          end
        end
      endcase
    end
    if (text_due.size() > n0) begin
      tail = text_due.pop_back();
      tail.fin = 1'b1;
      text_due.push_back(tail);
    end
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        strip_beat(char_in, end_of_line);
        beats_in++;
        if (idle_ok() && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 19);
      end
      // hold a stalled beat as it is
      if (!(item_valid && item_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          item_valid <= 1'b0;
        end else if (src_pending.size() > 0) begin
          nxt = src_pending.pop_front();
          char_in     <= nxt.ch;
          end_of_line <= nxt.eol;
          item_valid  <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        got.ch   = char_out;
        got.mark = line_mark;
        got.fin  = last;
        if (text_due.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected beat char_out=%02h line_mark=%0b last=%0b",
                     $time, got.ch, got.mark, got.fin);
        end else begin
          want = text_due.pop_front();
          if (got != want) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: mismatch expected char_out=%02h line_mark=%0b last=%0b,",
                       $time, want.ch, want.mark, want.fin,
                       " got char_out=%02h line_mark=%0b last=%0b",
                       got.ch, got.mark, got.fin);
          end
        end
      end
      // one long hold-off so the block backs up into its input
      if (!hold_done && beats_in >= HOLD_AT) begin
        hold_done  = 1'b1;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && idle_ok() && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 19);
      end
      if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int         len;
    logic [7:0] b;

    // directed: byte extremes, escaped quote, string with comment marks inside
    queue_beat(8'h00, 1'b0);
    queue_beat(8'hFF, 1'b0);
    queue_beat(CH_BACKSLASH, 1'b0);
    queue_beat(CH_QUOTE, 1'b0);
    queue_beat(CH_QUOTE, 1'b0);
    queue_beat(CH_SLASH, 1'b0);
    queue_beat(CH_STAR, 1'b0);
    queue_beat(CH_QUOTE, 1'b0);
    // held slash then a plain byte, then a held slash flushed by line end
    queue_beat(CH_SLASH, 1'b0);
    queue_beat(8'h78, 1'b0);
    queue_beat(CH_SLASH, 1'b0);
    queue_beat(8'h00, 1'b1);
    // block comment: opener star must not close, line-end star must not pair
    queue_beat(CH_SLASH, 1'b0);
    queue_beat(CH_STAR, 1'b0);
    queue_beat(CH_SLASH, 1'b0);
    queue_beat(CH_STAR, 1'b0);
    queue_beat(8'h00, 1'b1);
    queue_beat(CH_SLASH, 1'b0);
    queue_beat(CH_STAR, 1'b0);
    queue_beat(CH_SLASH, 1'b0);
    // line comment, then a string ended by line end
    queue_beat(CH_SLASH, 1'b0);
    queue_beat(CH_SLASH, 1'b0);
    queue_beat(8'h71, 1'b0);
    queue_beat(8'h00, 1'b1);
    queue_beat(CH_QUOTE, 1'b0);
    queue_beat(8'hFF, 1'b1);

    while (src_pending.size() < TEXT_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          len = $urandom_range(1, 6);
          repeat (len) queue_beat(8'($urandom_range(8'h61, 8'h7A)), 1'b0);
        end
        2: begin
          queue_beat(CH_SLASH, 1'b0);
          queue_beat(CH_SLASH, 1'b0);
          len = $urandom_range(0, 6);
          repeat (len) queue_beat(8'($urandom_range(0, 255)), 1'b0);
          queue_beat(8'($urandom_range(0, 255)), 1'b1);
        end
        3: begin
          queue_beat(CH_SLASH, 1'b0);
          queue_beat(CH_STAR, 1'b0);
          len = $urandom_range(0, 8);
          repeat (len) begin
            case ($urandom_range(0, 5))
              0: queue_beat(CH_STAR, 1'b0);
              1: queue_beat(CH_SLASH, 1'b0);
              2: queue_beat(8'($urandom_range(0, 255)), 1'b1);
              default: queue_beat(8'($urandom_range(0, 255)), 1'b0);
            endcase
          end
          queue_beat(CH_STAR, 1'b0);
          queue_beat(CH_SLASH, 1'b0);
        end
        4: begin
          queue_beat(CH_QUOTE, 1'b0);
          len = $urandom_range(0, 6);
          repeat (len) begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_QUOTE) b = 8'h78;
            queue_beat(b, 1'b0);
          end
          queue_beat(CH_QUOTE, 1'b0);
        end
        5: begin
          queue_beat(CH_BACKSLASH, 1'b0);
          queue_beat(CH_QUOTE, 1'b0);
        end
        6: queue_beat(8'($urandom_range(0, 255)), 1'b1);
        7: begin
          queue_beat(CH_SLASH, 1'b0);
          queue_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 3) == 0));
        end
        8: begin
          queue_beat(CH_STAR, 1'b0);
          queue_beat(CH_SLASH, 1'b0);
        end
        default: begin
          len = $urandom_range(1, 4);
          repeat (len)
            queue_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 7) == 0));
        end
      endcase
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (src_pending.size() != 0 || item_valid) @(posedge clk);
    while (text_due.size() != 0) @(posedge clk);
    // let any stray beats surface
    repeat (20) @(posedge clk);
    if (errors == 0 && text_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/cs_pkg.sv
rtl/core/cs_front.sv
rtl/core/cs_queue.sv
rtl/core/cs_back.sv
rtl/core/comment_stripper.sv
bench/comment_stripper_tb.sv
